// ----- hdl/plls_pkg.sv -----
// shared types and constants for the integer pll divider search
// no dependencies
`timescale 1ns / 1ps

package plls_pkg;

    localparam int unsigned TARGET_W = 32;
    localparam int unsigned REF_W    = 30;
    localparam int unsigned VCO_W    = 32;
    localparam int unsigned ERR_W    = 33;
    localparam int unsigned PPM_W    = 53;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned SCALE_W  = 20;
    localparam int unsigned CFG_IDX_W = 3;

    // divider unit sizing: largest dividend is error*PPM_SCALE, largest divisor is target
    localparam int unsigned DVD_W = 64;
    localparam int unsigned DVS_W = 32;

    localparam logic [SCALE_W-1:0] PPM_SCALE = 20'd1000000;

    localparam logic [REF_W-1:0]  REF_FREQ_RST = 30'd50000000;
    localparam logic [VCO_W-1:0]  VCO_MIN_RST  = 32'd600000000;
    localparam logic [VCO_W-1:0]  VCO_MAX_RST  = 32'd1600000000;
    localparam logic [REF_W-1:0]  PFD_MIN_RST  = 30'd5000000;
    localparam logic [REF_W-1:0]  PFD_MAX_RST  = 30'd325000000;
    localparam int unsigned       LIMIT_RST    = 510;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_FREQ  = 3'd0,
        CFG_VCO_MIN   = 3'd1,
        CFG_VCO_MAX   = 3'd2,
        CFG_PFD_MIN   = 3'd3,
        CFG_PFD_MAX   = 3'd4,
        CFG_MULT_LIM  = 3'd5,
        CFG_PREDIV_LIM = 3'd6,
        CFG_POSTDIV_LIM = 3'd7
    } t_cfg_idx;

    // one queued request: target and whether it is rejected outright
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                reject;
    } t_job;

endpackage

// ----- hdl/plls_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on nothing; shared by all divisions of the search
`timescale 1ns / 1ps

module plls_div #(
    parameter int unsigned DW = 64,
    parameter int unsigned VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int unsigned CNT_W = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW:0]   r_r;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_r[VW-1:0], r_q[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(DW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_r   <= fits ? trial - {1'b0, r_dvs} : trial;
                r_q   <= {r_q[DW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- hdl/plls_front.sv -----
// request front end: screens targets and holds them in a two-entry queue
// depends on plls_pkg
`timescale 1ns / 1ps

module plls_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [plls_pkg::TARGET_W-1:0] i_target_freq,
    input  logic [plls_pkg::REF_W-1:0]    i_ref_freq,
    output logic                          o_job_valid,
    output plls_pkg::t_job                o_job,
    input  logic                          i_job_pop
);
    import plls_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready     = r_cnt != 2'd2;
    assign push        = i_valid && o_ready;
    assign pop         = i_job_pop && o_job_valid;
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                // no reference clock means nothing to divide by: same as zero target
                r_mem[r_wp].target <= i_target_freq;
                r_mem[r_wp].reject <= (i_target_freq == '0) || (i_ref_freq == '0);
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hdl/plls_search.sv -----
// search sequencer: walks n, c and m, keeps the best candidate, holds the result
// depends on plls_pkg and plls_div
`timescale 1ns / 1ps

module plls_search #(
    parameter int unsigned MIN_DIVIDE   = 1,
    parameter int unsigned DIVIDER_BITS = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  plls_pkg::t_job                i_job,
    output logic                          o_job_pop,
    input  logic [plls_pkg::REF_W-1:0]    i_ref_freq,
    input  logic [plls_pkg::VCO_W-1:0]    i_vco_min,
    input  logic [plls_pkg::VCO_W-1:0]    i_vco_max,
    input  logic [plls_pkg::REF_W-1:0]    i_pfd_min,
    input  logic [plls_pkg::REF_W-1:0]    i_pfd_max,
    input  logic [DIVIDER_BITS-1:0]       i_mult_lim,
    input  logic [DIVIDER_BITS-1:0]       i_prediv_lim,
    input  logic [DIVIDER_BITS-1:0]       i_postdiv_lim,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic [DIVIDER_BITS-1:0]       o_mult_m,
    output logic [DIVIDER_BITS-1:0]       o_prediv_n,
    output logic [DIVIDER_BITS-1:0]       o_postdiv_c,
    output logic [plls_pkg::VCO_W-1:0]    o_vco_freq,
    output logic [plls_pkg::VCO_W-1:0]    o_actual_freq,
    output logic signed [plls_pkg::ERR_W-1:0] o_error_freq,
    output logic signed [plls_pkg::PPM_W-1:0] o_ppm_error,
    output logic [plls_pkg::COUNT_W-1:0]  o_evaluated_count
);
    import plls_pkg::*;

    localparam int unsigned DB = DIVIDER_BITS;
    localparam int unsigned CW = DIVIDER_BITS + 1;
    localparam int unsigned P1_W = TARGET_W + DIVIDER_BITS;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_N_TEST    = 14'b00000000000010,
        S_PFD_WAIT  = 14'b00000000000100,
        S_C_TEST    = 14'b00000000001000,
        S_MUL2      = 14'b00000000010000,
        S_M0_WAIT   = 14'b00000000100000,
        S_K_TEST    = 14'b00000001000000,
        S_VCO_WAIT  = 14'b00000010000000,
        S_FOUT_WAIT = 14'b00000100000000,
        S_EVAL      = 14'b00001000000000,
        S_K_NEXT    = 14'b00010000000000,
        S_FINISH    = 14'b00100000000000,
        S_PPM_WAIT  = 14'b01000000000000,
        S_RESULT    = 14'b10000000000000
    } t_state;

    t_state            r_state;
    logic [TARGET_W-1:0] r_target;
    logic              r_fail;
    logic              r_found;
    logic [COUNT_W-1:0] r_count;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_c;
    logic              r_k;
    logic [DVD_W-1:0]  r_m0;
    logic [DB-1:0]     r_m;
    logic [P1_W-1:0]   r_prod;
    logic [VCO_W-1:0]  r_vco;
    logic [VCO_W-1:0]  r_fout;
    logic [VCO_W-1:0]  r_berr;
    logic [DB-1:0]     r_bm;
    logic [DB-1:0]     r_bn;
    logic [DB-1:0]     r_bc;
    logic [VCO_W-1:0]  r_bvco;
    logic [VCO_W-1:0]  r_bact;
    logic              r_neg;
    logic [PPM_W-1:0]  r_ppm;
    logic              r_ovalid;

    logic              r_dstart;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;

    logic [DVD_W-1:0]  m_full;
    logic              m_ok;
    logic              vco_out;
    logic [VCO_W-1:0]  err;
    logic              better;
    logic signed [ERR_W-1:0] best_e;
    logic [ERR_W-1:0]  abs_e;

    plls_div #(.DW(DVD_W), .VW(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign m_full  = r_m0 + DVD_W'(r_k);
    assign m_ok    = (m_full >= DVD_W'(MIN_DIVIDE)) && (m_full <= DVD_W'(i_mult_lim));
    assign vco_out = (div_q < DVD_W'(i_vco_min)) || (div_q > DVD_W'(i_vco_max));
    assign err    = (r_fout > r_target) ? r_fout - r_target : r_target - r_fout;
    // ties go to the higher vco
    assign better = !r_found || (err < r_berr) || ((err == r_berr) && (r_vco > r_bvco));
    assign best_e = $signed({1'b0, r_bact}) - $signed({1'b0, r_target});
    assign abs_e  = best_e[ERR_W-1] ? ERR_W'(-best_e) : ERR_W'(best_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_RESULT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_target <= i_job.target;
                        r_found  <= 1'b0;
                        r_count  <= '0;
                        r_n      <= CW'(MIN_DIVIDE);
                        r_fail   <= i_job.reject;
                        r_state  <= i_job.reject ? S_RESULT : S_N_TEST;
                    end
                end
                S_N_TEST: begin
                    if (r_n > {1'b0, i_prediv_lim}) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_dvd    <= DVD_W'(i_ref_freq);
                        r_dvs    <= DVS_W'(r_n);
                        r_dstart <= 1'b1;
                        r_state  <= S_PFD_WAIT;
                    end
                end
                S_PFD_WAIT: begin
                    r_dstart <= 1'b0;
                    if (div_done) begin
                        if (div_q < DVD_W'(i_pfd_min)) begin
                            r_state <= S_FINISH;
                        end else if (div_q > DVD_W'(i_pfd_max)) begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_N_TEST;
                        end else begin
                            r_c     <= CW'(MIN_DIVIDE);
                            r_state <= S_C_TEST;
                        end
                    end
                end
                S_C_TEST: begin
                    if (r_c > {1'b0, i_postdiv_lim}) begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_N_TEST;
                    end else begin
                        r_prod  <= P1_W'(r_target * r_c[DB-1:0]);
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_dvd    <= DVD_W'(r_prod * r_n[DB-1:0]);
                    r_dvs    <= DVS_W'(i_ref_freq);
                    r_dstart <= 1'b1;
                    r_state  <= S_M0_WAIT;
                end
                S_M0_WAIT: begin
                    r_dstart <= 1'b0;
                    if (div_done) begin
                        r_m0    <= div_q;
                        r_k     <= 1'b0;
                        r_state <= S_K_TEST;
                    end
                end
                S_K_TEST: begin
                    if (m_ok) begin
                        r_m      <= m_full[DB-1:0];
                        r_dvd    <= DVD_W'(i_ref_freq * m_full[DB-1:0]);
                        r_dvs    <= DVS_W'(r_n);
                        r_dstart <= 1'b1;
                        r_state  <= S_VCO_WAIT;
                    end else begin
                        r_state <= S_K_NEXT;
                    end
                end
                S_VCO_WAIT: begin
                    // an in-band vco goes straight on to the output division
                    r_dstart <= div_done && !vco_out;
                    if (div_done) begin
                        r_vco <= div_q[VCO_W-1:0];
                        if (vco_out) begin
                            r_state <= S_K_NEXT;
                        end else begin
                            r_dvd   <= div_q;
                            r_dvs   <= DVS_W'(r_c);
                            r_state <= S_FOUT_WAIT;
                        end
                    end
                end
                S_FOUT_WAIT: begin
                    r_dstart <= 1'b0;
                    if (div_done) begin
                        r_fout  <= div_q[VCO_W-1:0];
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_count <= r_count + 1'b1;
                    if (better) begin
                        r_found <= 1'b1;
                        r_berr  <= err;
                        r_bvco  <= r_vco;
                        r_bm    <= r_m;
                        r_bn    <= r_n[DB-1:0];
                        r_bc    <= r_c[DB-1:0];
                        r_bact  <= r_fout;
                        // exact hit high enough in the vco band ends the search
                        if (err == '0 && r_vco >= (i_vco_max >> 1)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_K_NEXT;
                        end
                    end else begin
                        r_state <= S_K_NEXT;
                    end
                end
                S_K_NEXT: begin
                    if (!r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_K_TEST;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_C_TEST;
                    end
                end
                S_FINISH: begin
                    if (!r_found) begin
                        r_fail  <= 1'b1;
                        r_state <= S_RESULT;
                    end else begin
                        r_neg    <= best_e[ERR_W-1];
                        r_dvd    <= DVD_W'(abs_e * PPM_SCALE);
                        r_dvs    <= r_target;
                        r_dstart <= 1'b1;
                        r_state  <= S_PPM_WAIT;
                    end
                end
                S_PPM_WAIT: begin
                    r_dstart <= 1'b0;
                    if (div_done) begin
                        r_ppm   <= r_neg ? PPM_W'(-div_q[PPM_W-1:0]) : div_q[PPM_W-1:0];
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid          <= 1'b1;
                        o_status          <= r_fail;
                        o_mult_m          <= r_fail ? '0 : r_bm;
                        o_prediv_n        <= r_fail ? '0 : r_bn;
                        o_postdiv_c       <= r_fail ? '0 : r_bc;
                        o_vco_freq        <= r_fail ? '0 : r_bvco;
                        o_actual_freq     <= r_fail ? '0 : r_bact;
                        o_error_freq      <= r_fail ? '0 : best_e;
                        o_ppm_error       <= r_fail ? '0 : $signed(r_ppm);
                        o_evaluated_count <= r_fail ? '0 : r_count;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ----- hdl/pll_integer_divider_search_unit.sv -----
// integer-n pll divider search: one item in, one result out once its search ends or it is rejected
// every division runs on the single shared bit-serial divider
// throughput: one item at a time; a two-item queue in front and an output register let the
// neighbors keep handing over and taking items; synchronous active-low reset restores the
// configuration registers to their defaults, empties the queue and drops any result
`timescale 1ns / 1ps

module pll_integer_divider_search_unit #(
    parameter int unsigned MIN_DIVIDE   = 1,
    parameter int unsigned DIVIDER_BITS = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [plls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [plls_pkg::TARGET_W-1:0]         i_target_freq,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_status,
    output logic [DIVIDER_BITS-1:0]               o_mult_m,
    output logic [DIVIDER_BITS-1:0]               o_prediv_n,
    output logic [DIVIDER_BITS-1:0]               o_postdiv_c,
    output logic [plls_pkg::VCO_W-1:0]            o_vco_freq,
    output logic [plls_pkg::VCO_W-1:0]            o_actual_freq,
    output logic signed [plls_pkg::ERR_W-1:0]     o_error_freq,
    output logic signed [plls_pkg::PPM_W-1:0]     o_ppm_error,
    output logic [plls_pkg::COUNT_W-1:0]          o_evaluated_count
);
    import plls_pkg::*;

    logic [REF_W-1:0]        r_ref_freq;
    logic [VCO_W-1:0]        r_vco_min;
    logic [VCO_W-1:0]        r_vco_max;
    logic [REF_W-1:0]        r_pfd_min;
    logic [REF_W-1:0]        r_pfd_max;
    logic [DIVIDER_BITS-1:0] r_mult_lim;
    logic [DIVIDER_BITS-1:0] r_prediv_lim;
    logic [DIVIDER_BITS-1:0] r_postdiv_lim;

    logic job_valid;
    t_job job;
    logic job_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq    <= REF_FREQ_RST;
            r_vco_min     <= VCO_MIN_RST;
            r_vco_max     <= VCO_MAX_RST;
            r_pfd_min     <= PFD_MIN_RST;
            r_pfd_max     <= PFD_MAX_RST;
            r_mult_lim    <= DIVIDER_BITS'(LIMIT_RST);
            r_prediv_lim  <= DIVIDER_BITS'(LIMIT_RST);
            r_postdiv_lim <= DIVIDER_BITS'(LIMIT_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REF_FREQ:    r_ref_freq    <= i_cfg_data[REF_W-1:0];
                CFG_VCO_MIN:     r_vco_min     <= i_cfg_data[VCO_W-1:0];
                CFG_VCO_MAX:     r_vco_max     <= i_cfg_data[VCO_W-1:0];
                CFG_PFD_MIN:     r_pfd_min     <= i_cfg_data[REF_W-1:0];
                CFG_PFD_MAX:     r_pfd_max     <= i_cfg_data[REF_W-1:0];
                CFG_MULT_LIM:    r_mult_lim    <= i_cfg_data[DIVIDER_BITS-1:0];
                CFG_PREDIV_LIM:  r_prediv_lim  <= i_cfg_data[DIVIDER_BITS-1:0];
                CFG_POSTDIV_LIM: r_postdiv_lim <= i_cfg_data[DIVIDER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    plls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_target_freq (i_target_freq),
        .i_ref_freq    (r_ref_freq),
        .o_job_valid   (job_valid),
        .o_job         (job),
        .i_job_pop     (job_pop)
    );

    plls_search #(
        .MIN_DIVIDE   (MIN_DIVIDE),
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_search (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (job_valid),
        .i_job             (job),
        .o_job_pop         (job_pop),
        .i_ref_freq        (r_ref_freq),
        .i_vco_min         (r_vco_min),
        .i_vco_max         (r_vco_max),
        .i_pfd_min         (r_pfd_min),
        .i_pfd_max         (r_pfd_max),
        .i_mult_lim        (r_mult_lim),
        .i_prediv_lim      (r_prediv_lim),
        .i_postdiv_lim     (r_postdiv_lim),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_mult_m          (o_mult_m),
        .o_prediv_n        (o_prediv_n),
        .o_postdiv_c       (o_postdiv_c),
        .o_vco_freq        (o_vco_freq),
        .o_actual_freq     (o_actual_freq),
        .o_error_freq      (o_error_freq),
        .o_ppm_error       (o_ppm_error),
        .o_evaluated_count (o_evaluated_count)
    );

endmodule

// ----- test/pll_integer_divider_search_unit_tb.sv -----
// testbench for pll_integer_divider_search_unit: directed rows, then random register settings
// and targets, checked against an in-bench search or known failure; depends on plls_pkg, rtl
`timescale 1ns / 1ps

module pll_integer_divider_search_unit_tb;
    import plls_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 30000000;

    typedef struct {
        logic                     status;
        logic [8:0]               mult_m;
        logic [8:0]               prediv_n;
        logic [8:0]               postdiv_c;
        logic [31:0]              vco_freq;
        logic [31:0]              actual_freq;
        logic signed [ERR_W-1:0]  error_freq;
        logic signed [PPM_W-1:0]  ppm_error;
        logic [COUNT_W-1:0]       evaluated_count;
    } pll_solution_t;

    // one directed row: register values, target, and whether the answer is a plain failure
    typedef struct {
        logic [31:0] regs [8];
        logic [31:0] target;
        bit          known_fail;
    } directed_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_target_freq = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_status;
    logic [8:0]  o_mult_m, o_prediv_n, o_postdiv_c;
    logic [31:0] o_vco_freq, o_actual_freq;
    logic signed [ERR_W-1:0] o_error_freq;
    logic signed [PPM_W-1:0] o_ppm_error;
    logic [COUNT_W-1:0] o_evaluated_count;

    // register copies as the block should hold them
    longint unsigned ref_hz, vco_lo, vco_hi, pfd_lo, pfd_hi, m_lim, n_lim, c_lim;
    logic [31:0] cur_regs [8];

    pll_solution_t pending_solutions [$];
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned found_seen = 0;
    int unsigned cycle_count = 0;
    bit          idling_on = 1'b1;
    int unsigned stall_left = 0;

    pll_integer_divider_search_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_target_freq     (i_target_freq),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_mult_m          (o_mult_m),
        .o_prediv_n        (o_prediv_n),
        .o_postdiv_c       (o_postdiv_c),
        .o_vco_freq        (o_vco_freq),
        .o_actual_freq     (o_actual_freq),
        .o_error_freq      (o_error_freq),
        .o_ppm_error       (o_ppm_error),
        .o_evaluated_count (o_evaluated_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic pll_solution_t failed_solution();
        pll_solution_t r;
        r = '{default: '0};
        r.status = 1'b1;
        return r;
    endfunction

    // exhaustive n/c/m search with early exit on an exact hit high in the vco band
    function automatic pll_solution_t search_dividers(longint unsigned tgt);
        pll_solution_t   r;
        longint unsigned low_err, low_vco, bm, bn, bc, bvco, bact, cnt;
        longint unsigned n, c, m0, m, vco, fout, err, pfd;
        longint          e, ppm;
        bit              found, stop;
        r = failed_solution();
        low_err = '1;
        low_vco = 0;
        bm = 0; bn = 0; bc = 0; bvco = 0; bact = 0; cnt = 0;
        found = 1'b0;
        stop = 1'b0;
        if (tgt == 0 || ref_hz == 0)
            return r;
        for (n = 1; n <= n_lim && !stop; n++) begin
            pfd = ref_hz / n;
            if (pfd < pfd_lo)
                break;
            if (pfd > pfd_hi)
                continue;
            for (c = 1; c <= c_lim && !stop; c++) begin
                m0 = (tgt * c * n) / ref_hz;
                for (int k = 0; k < 2; k++) begin
                    m = m0 + k;
                    if (m < 1 || m > m_lim)
                        continue;
                    vco = ref_hz * m / n;
                    if (vco < vco_lo || vco > vco_hi)
                        continue;
                    fout = vco / c;
                    err = (fout > tgt) ? fout - tgt : tgt - fout;
                    cnt++;
                    if (err < low_err || (err == low_err && vco > low_vco)) begin
                        low_err = err;
                        low_vco = vco;
                        bm = m; bn = n; bc = c; bvco = vco; bact = fout;
                        found = 1'b1;
                        if (err == 0 && vco >= vco_hi / 2) begin
                            stop = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        if (!found)
            return r;
        e = longint'(bact) - longint'(tgt);
        ppm = (e * 1000000) / longint'(tgt);
        r.status = 1'b0;
        r.mult_m = bm[8:0];
        r.prediv_n = bn[8:0];
        r.postdiv_c = bc[8:0];
        r.vco_freq = bvco[31:0];
        r.actual_freq = bact[31:0];
        r.error_freq = e[ERR_W-1:0];
        r.ppm_error = ppm[PPM_W-1:0];
        r.evaluated_count = cnt[COUNT_W-1:0];
        return r;
    endfunction

    // receiver side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pll_solution_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (!o_status)
                found_seen++;
            if (pending_solutions.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = pending_solutions.pop_front();
                if (o_status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_status); fail_count++;
                end
                if (o_mult_m !== want.mult_m) begin
                    $error("mult_m exp %0d got %0d", want.mult_m, o_mult_m); fail_count++;
                end
                if (o_prediv_n !== want.prediv_n) begin
                    $error("prediv_n exp %0d got %0d", want.prediv_n, o_prediv_n); fail_count++;
                end
                if (o_postdiv_c !== want.postdiv_c) begin
                    $error("postdiv_c exp %0d got %0d", want.postdiv_c, o_postdiv_c);
                    fail_count++;
                end
                if (o_vco_freq !== want.vco_freq) begin
                    $error("vco_freq exp %0d got %0d", want.vco_freq, o_vco_freq); fail_count++;
                end
                if (o_actual_freq !== want.actual_freq) begin
                    $error("actual_freq exp %0d got %0d", want.actual_freq, o_actual_freq);
                    fail_count++;
                end
                if (o_error_freq !== want.error_freq) begin
                    $error("error_freq exp %0d got %0d", want.error_freq, o_error_freq);
                    fail_count++;
                end
                if (o_ppm_error !== want.ppm_error) begin
                    $error("ppm_error exp %0d got %0d", want.ppm_error, o_ppm_error);
                    fail_count++;
                end
                if (o_evaluated_count !== want.evaluated_count) begin
                    $error("evaluated_count exp %0d got %0d", want.evaluated_count,
                           o_evaluated_count);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain_results();
        while (pending_solutions.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REF_FREQ:    ref_hz = data[29:0];
            CFG_VCO_MIN:     vco_lo = data;
            CFG_VCO_MAX:     vco_hi = data;
            CFG_PFD_MIN:     pfd_lo = data[29:0];
            CFG_PFD_MAX:     pfd_hi = data[29:0];
            CFG_MULT_LIM:    m_lim = data[8:0];
            CFG_PREDIV_LIM:  n_lim = data[8:0];
            CFG_POSTDIV_LIM: c_lim = data[8:0];
            default: ;
        endcase
        cur_regs[idx] = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] regs [8]);
        drain_results();
        for (int i = 0; i < 8; i++)
            write_reg(t_cfg_idx'(i), regs[i]);
    endtask

    // valid stays up between back-to-back items and drops only for a gap
    task automatic send_target(input logic [31:0] tgt, input bit known_fail);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_freq <= tgt;
        do @(posedge i_clk); while (!o_ready);
        pending_solutions.push_back(known_fail ? failed_solution() : search_dividers(tgt));
        items_sent++;
    endtask

    function automatic logic [31:0] with_noise(logic [31:0] value, int unsigned width);
        logic [31:0] r;
        r = $urandom;
        for (int b = 0; b < 32; b++)
            if (b < width)
                r[b] = value[b];
        return r;
    endfunction

    task automatic random_phase(input int unsigned count, input bit pause_midway);
        logic [31:0] regs [8];
        longint unsigned rf, vl, m, n, c, t;
        rf = $urandom_range(1000000, 200000000);
        vl = $urandom_range(0, 1000000000);
        regs[CFG_REF_FREQ] = with_noise(rf, 30);
        regs[CFG_VCO_MIN] = vl;
        regs[CFG_VCO_MAX] = vl + $urandom_range(0, 2000000000);
        regs[CFG_PFD_MIN] = with_noise($urandom_range(0, rf / 4), 30);
        regs[CFG_PFD_MAX] = with_noise($urandom_range(rf / 8, 1000000000), 30);
        regs[CFG_MULT_LIM] = with_noise($urandom_range(1, 511), 9);
        regs[CFG_PREDIV_LIM] = with_noise($urandom_range(1, 4), 9);
        regs[CFG_POSTDIV_LIM] = with_noise($urandom_range(1, 6), 9);
        load_regs(regs);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                i_valid <= 1'b0;
                drain_results();
            end
            if ($urandom_range(0, 99) < 85) begin
                // a target near a reachable divider combination
                m = $urandom_range(1, m_lim);
                n = $urandom_range(1, n_lim);
                c = $urandom_range(1, c_lim);
                t = ref_hz * m / (n * c) + $urandom_range(0, 3);
                send_target(t[31:0], 1'b0);
            end else begin
                send_target($urandom, 1'b0);
            end
        end
    endtask

    directed_row_t rows [$];

    function automatic directed_row_t make_row(longint unsigned rf, longint unsigned vl,
                                               longint unsigned vh, longint unsigned pl,
                                               longint unsigned ph, int unsigned ml,
                                               int unsigned nl, int unsigned cl,
                                               logic [31:0] tgt, bit known_fail);
        directed_row_t r;
        r.regs[CFG_REF_FREQ] = rf;
        r.regs[CFG_VCO_MIN] = vl;
        r.regs[CFG_VCO_MAX] = vh;
        r.regs[CFG_PFD_MIN] = pl;
        r.regs[CFG_PFD_MAX] = ph;
        r.regs[CFG_MULT_LIM] = ml;
        r.regs[CFG_PREDIV_LIM] = nl;
        r.regs[CFG_POSTDIV_LIM] = cl;
        r.target = tgt;
        r.known_fail = known_fail;
        return r;
    endfunction

    initial begin
        bit differs;
        ref_hz = REF_FREQ_RST; vco_lo = VCO_MIN_RST; vco_hi = VCO_MAX_RST;
        pfd_lo = PFD_MIN_RST; pfd_hi = PFD_MAX_RST;
        m_lim = LIMIT_RST; n_lim = LIMIT_RST; c_lim = LIMIT_RST;
        cur_regs = '{REF_FREQ_RST, VCO_MIN_RST, VCO_MAX_RST, PFD_MIN_RST, PFD_MAX_RST,
                     LIMIT_RST, LIMIT_RST, LIMIT_RST};

        // reset values first, then extremes and empty ranges
        rows.push_back(make_row(50000000, 600000000, 1600000000, 5000000, 325000000,
                                510, 510, 510, 32'd0, 1'b1));
        rows.push_back(make_row(50000000, 600000000, 1600000000, 5000000, 325000000,
                                510, 510, 510, 32'd100000000, 1'b0));
        rows.push_back(make_row(50000000, 600000000, 1600000000, 5000000, 325000000,
                                510, 510, 510, 32'd25000000, 1'b0));
        rows.push_back(make_row(32'h3FFFFFFF, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 2, 3, 32'd1, 1'b0));
        rows.push_back(make_row(32'h3FFFFFFF, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 2, 3, 32'hFFFFFFFF, 1'b0));
        rows.push_back(make_row(32'h3FFFFFFF, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 2, 3, 32'h55555555, 1'b0));
        rows.push_back(make_row(32'h3FFFFFFF, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 2, 3, 32'hAAAAAAAA, 1'b0));
        rows.push_back(make_row(1, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 3, 3, 32'd1, 1'b0));
        // zero reference behaves like a zero target
        rows.push_back(make_row(0, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 3, 3, 32'd12345, 1'b1));
        // empty divider ranges
        rows.push_back(make_row(50000000, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                0, 3, 3, 32'd12345, 1'b1));
        rows.push_back(make_row(50000000, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 0, 3, 32'd12345, 1'b1));
        rows.push_back(make_row(50000000, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                511, 3, 0, 32'd12345, 1'b1));
        // vco band inverted: nothing fits
        rows.push_back(make_row(50000000, 1600000000, 600000000, 0, 32'h3FFFFFFF,
                                511, 3, 3, 32'd100000000, 1'b1));
        // pfd band above the reference: search breaks at once
        rows.push_back(make_row(50000000, 0, 32'hFFFFFFFF, 32'h3FFFFFFF, 32'h3FFFFFFF,
                                511, 511, 3, 32'd100000000, 1'b1));
        // long post-divider walk and a huge m0 that must not wrap
        rows.push_back(make_row(50000000, 600000000, 1600000000, 5000000, 325000000,
                                511, 1, 511, 32'd1234567, 1'b0));
        rows.push_back(make_row(50000000, 0, 32'hFFFFFFFF, 0, 32'h3FFFFFFF,
                                1, 511, 2, 32'hFFFFFFFF, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            differs = 1'b0;
            for (int i = 0; i < 8; i++)
                if (rows[r].regs[i] !== cur_regs[i])
                    differs = 1'b1;
            if (differs) begin
                i_valid <= 1'b0;
                load_regs(rows[r].regs);
            end
            send_target(rows[r].target, rows[r].known_fail);
        end

        for (int p = 0; p < 6; p++) begin
            i_valid <= 1'b0;
            if (p == 5) begin
                drain_results();
                idling_on = 1'b0;
            end
            random_phase(17, p == 2);
        end
        i_valid <= 1'b0;

        drain_results();
        repeat (200) @(posedge i_clk);

        $display("sent %0d targets over directed rows and 6 random register settings",
                 items_sent);
        $display("checked %0d results, %0d with a divider solution", results_seen, found_seen);
        if (fail_count == 0 && pending_solutions.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
